// ===== rtl/core/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg
// Shared constants for the addressed frame receiver: item kinds, receive
// phases, register indexes and field widths.
// ----------------------------------------------------------------------------
package afr_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 64;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 3;
   localparam int POS_W       = 6;
   localparam int PHASE_W     = 2;
   localparam int CSR_INDEX_W = 3;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_BYTE        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DISABLE_RX  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET_START   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ        = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR_FLAGS = 3'd4;

   // Receive phases.
   localparam logic [PHASE_W-1:0] PH_WAIT_START  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_WAIT_ID     = 2'd1;
   localparam logic [PHASE_W-1:0] PH_WAIT_SUB_ID = 2'd2;
   localparam logic [PHASE_W-1:0] PH_STORE       = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_ID     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_SUB_ID = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BROADCAST_ID  = 3'd4;

endpackage

// ===== rtl/core/afr_ram.sv =====
// ----------------------------------------------------------------------------
// afr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when read enable is high.
// ----------------------------------------------------------------------------
module afr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/addressed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Deframes start/id/sub id/data/end byte frames from a shared line into a
// ring buffer, with disable, consumer index, read and flag clear items.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then moves into the
// result register and buffer read register when it advances, which a held
// result can stall.
// Throughput: one item per cycle while responses are not stalled; the single
// buffer write port and the phase update never hold an item back.
// Reset clears the phase, pointers, flags and configuration registers; buffer
// contents are undefined until written.
module addressed_frame_receiver #(
   parameter int BUFFER_DEPTH = afr_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration.
   input  logic                               csr_we,
   input  logic [afr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afr_pkg::BYTE_W-1:0]         csr_wdata,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [afr_pkg::KIND_W-1:0]         req_kind,
   input  logic [afr_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic [afr_pkg::POS_W-1:0]          req_index,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_frame_done,
   output logic                               rsp_request_pending,
   output logic                               rsp_overflow,
   output logic [afr_pkg::PHASE_W-1:0]        rsp_rx_phase,
   output logic                               rsp_readback_disabled,
   output logic [afr_pkg::POS_W-1:0]          rsp_write_position,
   output logic [afr_pkg::POS_W-1:0]          rsp_end_position,
   output logic [afr_pkg::BYTE_W-1:0]         rsp_read_data
);

   localparam int AW          = $clog2(BUFFER_DEPTH);
   localparam int INDEX_COUNT = 2 ** afr_pkg::POS_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

   // Configuration registers.
   logic [afr_pkg::BYTE_W-1:0] start_code_ff, end_code_ff;
   logic [afr_pkg::BYTE_W-1:0] module_id_ff, module_sub_id_ff, broadcast_id_ff;

   // Input register.
   logic                        in_valid_ff;
   logic [afr_pkg::KIND_W-1:0]  kind_ff;
   logic [afr_pkg::BYTE_W-1:0]  rx_byte_ff;
   logic [afr_pkg::POS_W-1:0]   index_ff;

   // Receiver state.
   logic [afr_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                        rx_dis_ff, rx_dis_in;
   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]               start_ptr_ff, start_ptr_in;
   logic [AW-1:0]               end_ptr_ff, end_ptr_in;
   logic                        ovf_ff, ovf_in;
   logic                        req_flag_ff, req_flag_in;

   // Result register.
   logic                        out_valid_ff;
   logic                        done_ff, done_in;
   logic                        rd_sel_ff;

   logic                        advance;
   logic                        ram_we, ram_re;
   logic [AW-1:0]               idx_wrap [INDEX_COUNT];
   logic [AW-1:0]               wr_next, wr_after, before_end;
   logic [afr_pkg::BYTE_W-1:0]  ram_q;

   // Index reduction modulo the buffer depth, as a constant table.
   for (genvar g = 0; g < INDEX_COUNT; g++) begin : g_idx
      assign idx_wrap[g] = AW'(g % BUFFER_DEPTH);
   end

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign wr_next    = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
   assign wr_after   = (wr_next == LAST_SLOT) ? '0 : wr_next + AW'(1);
   assign before_end = (end_ptr_ff == '0) ? LAST_SLOT : end_ptr_ff - AW'(1);

   always_comb begin
      phase_in     = phase_ff;
      rx_dis_in    = rx_dis_ff;
      wr_ptr_in    = wr_ptr_ff;
      start_ptr_in = start_ptr_ff;
      end_ptr_in   = end_ptr_ff;
      ovf_in       = ovf_ff;
      req_flag_in  = req_flag_ff;
      done_in      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      unique case (kind_ff)
         afr_pkg::KIND_BYTE: begin
            if (rx_dis_ff) begin
               if (rx_byte_ff == end_code_ff) begin
                  rx_dis_in = 1'b0;
               end
            end else begin
               unique case (phase_ff)
                  afr_pkg::PH_WAIT_START: begin
                     if (rx_byte_ff == start_code_ff) begin
                        phase_in = afr_pkg::PH_WAIT_ID;
                     end
                  end
                  afr_pkg::PH_WAIT_ID: begin
                     phase_in = (rx_byte_ff == module_id_ff || rx_byte_ff == broadcast_id_ff)
                              ? afr_pkg::PH_WAIT_SUB_ID : afr_pkg::PH_WAIT_START;
                  end
                  afr_pkg::PH_WAIT_SUB_ID: begin
                     phase_in = (rx_byte_ff == module_sub_id_ff ||
                                 rx_byte_ff == broadcast_id_ff)
                              ? afr_pkg::PH_STORE : afr_pkg::PH_WAIT_START;
                  end
                  afr_pkg::PH_STORE: begin
                     ram_we    = advance;
                     wr_ptr_in = wr_next;
                     if (wr_next == start_ptr_ff && wr_next != before_end) begin
                        ovf_in = 1'b1;
                     end
                     if (rx_byte_ff == end_code_ff) begin
                        end_ptr_in  = wr_after;
                        req_flag_in = 1'b1;
                        phase_in    = afr_pkg::PH_WAIT_START;
                        done_in     = 1'b1;
                     end
                  end
               endcase
            end
         end
         afr_pkg::KIND_DISABLE_RX: begin
            rx_dis_in = 1'b1;
         end
         afr_pkg::KIND_SET_START: begin
            start_ptr_in = idx_wrap[index_ff];
         end
         afr_pkg::KIND_READ: begin
            ram_re = advance;
         end
         afr_pkg::KIND_CLEAR_FLAGS: begin
            req_flag_in = 1'b0;
            ovf_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff    <= '0;
         end_code_ff      <= '0;
         module_id_ff     <= '0;
         module_sub_id_ff <= '0;
         broadcast_id_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            afr_pkg::CSR_START_CODE:    start_code_ff    <= csr_wdata;
            afr_pkg::CSR_END_CODE:      end_code_ff      <= csr_wdata;
            afr_pkg::CSR_MODULE_ID:     module_id_ff     <= csr_wdata;
            afr_pkg::CSR_MODULE_SUB_ID: module_sub_id_ff <= csr_wdata;
            afr_pkg::CSR_BROADCAST_ID:  broadcast_id_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         kind_ff    <= req_kind;
         rx_byte_ff <= req_rx_byte;
         index_ff   <= req_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= afr_pkg::PH_WAIT_START;
         rx_dis_ff    <= 1'b0;
         wr_ptr_ff    <= '0;
         start_ptr_ff <= '0;
         end_ptr_ff   <= '0;
         ovf_ff       <= 1'b0;
         req_flag_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff     <= phase_in;
            rx_dis_ff    <= rx_dis_in;
            wr_ptr_ff    <= wr_ptr_in;
            start_ptr_ff <= start_ptr_in;
            end_ptr_ff   <= end_ptr_in;
            ovf_ff       <= ovf_in;
            req_flag_ff  <= req_flag_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         done_ff   <= done_in;
         rd_sel_ff <= (kind_ff == afr_pkg::KIND_READ);
      end
   end

   afr_ram #(
      .WIDTH (afr_pkg::BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (rx_byte_ff),
      .rd_en   (ram_re),
      .rd_addr (idx_wrap[index_ff]),
      .rd_data (ram_q)
   );

   // The state only moves when an item advances into the result register, so
   // the live state is the status of the item being presented.
   assign rsp_valid             = out_valid_ff;
   assign rsp_frame_done        = done_ff;
   assign rsp_request_pending   = req_flag_ff;
   assign rsp_overflow          = ovf_ff;
   assign rsp_rx_phase          = phase_ff;
   assign rsp_readback_disabled = rx_dis_ff;
   assign rsp_write_position    = afr_pkg::POS_W'(wr_ptr_ff);
   assign rsp_end_position      = afr_pkg::POS_W'(end_ptr_ff);
   assign rsp_read_data         = rd_sel_ff ? ram_q : '0;

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_rx_phase == afr_pkg::PH_WAIT_START && rsp_request_pending &&
         !rsp_readback_disabled)
      else $error("frame end reported without matching status");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> phase_ff == afr_pkg::PH_STORE && !rx_dis_ff && in_valid_ff)
      else $error("buffer written outside the storing phase");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=>
         $stable(phase_ff) && $stable(wr_ptr_ff) && $stable(end_ptr_ff) &&
         $stable(ovf_ff) && $stable(req_flag_ff))
      else $error("receiver state moved while a result was held");

endmodule

// ===== test/tb_addressed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_addressed_frame_receiver
// Self-checking bench for the addressed frame receiver. A queue of words is
// filled per configuration setting, driven with random gaps and checked
// against an in-bench model of the deframer, its ring buffer and flags.
// ----------------------------------------------------------------------------
module tb_addressed_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [afr_pkg::KIND_W-1:0] KIND_RESERVED_FIRST = 3'd5;
   localparam logic [afr_pkg::KIND_W-1:0] KIND_RESERVED_MID   = 3'd6;
   localparam logic [afr_pkg::KIND_W-1:0] KIND_RESERVED_LAST  = 3'd7;
   // The shadow positions wrap at their own width, which matches this depth.
   localparam int DEPTH = afr_pkg::BUFFER_DEPTH_DEFAULT;

   typedef struct packed {
      logic [afr_pkg::KIND_W-1:0]  kind;
      logic [afr_pkg::BYTE_W-1:0]  rx_byte;
      logic [afr_pkg::POS_W-1:0]   index;
   } line_word_type;

   typedef struct packed {
      logic                        frame_done;
      logic                        request_pending;
      logic                        overflow;
      logic [afr_pkg::PHASE_W-1:0] rx_phase;
      logic                        readback_disabled;
      logic [afr_pkg::POS_W-1:0]   write_position;
      logic [afr_pkg::POS_W-1:0]   end_position;
      logic [afr_pkg::BYTE_W-1:0]  read_data;
   } rx_status_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [afr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [afr_pkg::BYTE_W-1:0]      csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [afr_pkg::KIND_W-1:0]      req_kind = '0;
   logic [afr_pkg::BYTE_W-1:0]      req_rx_byte = '0;
   logic [afr_pkg::POS_W-1:0]       req_index = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_frame_done;
   logic                            rsp_request_pending;
   logic                            rsp_overflow;
   logic [afr_pkg::PHASE_W-1:0]     rsp_rx_phase;
   logic                            rsp_readback_disabled;
   logic [afr_pkg::POS_W-1:0]       rsp_write_position;
   logic [afr_pkg::POS_W-1:0]       rsp_end_position;
   logic [afr_pkg::BYTE_W-1:0]      rsp_read_data;

   addressed_frame_receiver #(.BUFFER_DEPTH(DEPTH)) i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   line_word_type  pending_words[$];
   rx_status_type  expected_status[$];
   line_word_type  cur_word;
   int unsigned    words_accepted = 0;
   int unsigned    words_queued = 0;
   bit             failed = 1'b0;
   logic           steady;

   // Shadow configuration and receiver state.
   logic [afr_pkg::BYTE_W-1:0]  cfg_start, cfg_end, cfg_module, cfg_sub, cfg_broadcast;
   logic [afr_pkg::PHASE_W-1:0] rx_phase_q = afr_pkg::PH_WAIT_START;
   logic                        rx_off = 1'b0;
   logic [afr_pkg::POS_W-1:0]   wr_pos = '0;
   logic [afr_pkg::POS_W-1:0]   start_pos = '0;
   logic [afr_pkg::POS_W-1:0]   end_pos = '0;
   logic                        ovf_flag = 1'b0;
   logic                        req_flag = 1'b0;
   logic [afr_pkg::BYTE_W-1:0]  frame_mem [DEPTH];

   // A long stretch in the middle of the run goes without any idling.
   assign steady = (words_accepted >= 200) && (words_accepted < 330);

   function automatic logic [afr_pkg::BYTE_W-1:0] rand_byte();
      return afr_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [afr_pkg::POS_W-1:0] rand_index();
      return afr_pkg::POS_W'($urandom_range(0, DEPTH - 1));
   endfunction

   task automatic step_receiver(input line_word_type w, output rx_status_type s);
      logic                        done;
      logic [afr_pkg::BYTE_W-1:0]  data;
      logic [afr_pkg::POS_W-1:0]   before_end;
      done = 1'b0;
      data = '0;
      unique case (w.kind)
         afr_pkg::KIND_BYTE: begin
            if (rx_off) begin
               if (w.rx_byte == cfg_end) rx_off = 1'b0;
            end else begin
               unique case (rx_phase_q)
                  afr_pkg::PH_WAIT_START: begin
                     if (w.rx_byte == cfg_start) rx_phase_q = afr_pkg::PH_WAIT_ID;
                  end
                  afr_pkg::PH_WAIT_ID: begin
                     rx_phase_q = (w.rx_byte == cfg_module || w.rx_byte == cfg_broadcast) ?
                                  afr_pkg::PH_WAIT_SUB_ID : afr_pkg::PH_WAIT_START;
                  end
                  afr_pkg::PH_WAIT_SUB_ID: begin
                     rx_phase_q = (w.rx_byte == cfg_sub || w.rx_byte == cfg_broadcast) ?
                                  afr_pkg::PH_STORE : afr_pkg::PH_WAIT_START;
                  end
                  default: begin
                     frame_mem[wr_pos] = w.rx_byte;
                     wr_pos = wr_pos + 1'b1;
                     before_end = end_pos - 1'b1;
                     // Overflow uses the slot just before the end index as an exception.
                     if (wr_pos == start_pos && wr_pos != before_end) ovf_flag = 1'b1;
                     if (w.rx_byte == cfg_end) begin
                        end_pos = wr_pos + 1'b1;
                        req_flag = 1'b1;
                        rx_phase_q = afr_pkg::PH_WAIT_START;
                        done = 1'b1;
                     end
                  end
               endcase
            end
         end
         afr_pkg::KIND_DISABLE_RX: rx_off = 1'b1;
         afr_pkg::KIND_SET_START:  start_pos = w.index;
         afr_pkg::KIND_READ:       data = frame_mem[w.index];
         afr_pkg::KIND_CLEAR_FLAGS: begin
            req_flag = 1'b0;
            ovf_flag = 1'b0;
         end
         default: ;
      endcase
      s.frame_done        = done;
      s.request_pending   = req_flag;
      s.overflow          = ovf_flag;
      s.rx_phase          = rx_phase_q;
      s.readback_disabled = rx_off;
      s.write_position    = wr_pos;
      s.end_position      = end_pos;
      s.read_data         = data;
   endtask

   // Driver: a word moves when valid is high and stall is low.
   always @(posedge clock) begin
      rx_status_type st;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_receiver(cur_word, st);
            expected_status.push_back(st);
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 17)) begin
               cur_word = pending_words.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= cur_word.kind;
               req_rx_byte <= cur_word.rx_byte;
               req_index   <= cur_word.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // Monitor: compares each response word with the oldest expectation.
   always @(posedge clock) begin
      rx_status_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("response word arrived with no expectation waiting");
               failed = 1'b1;
            end else begin
               want = expected_status.pop_front();
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
               check_field("request_pending", 32'(want.request_pending),
                           32'(rsp_request_pending));
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
               check_field("rx_phase", 32'(want.rx_phase), 32'(rsp_rx_phase));
               check_field("readback_disabled", 32'(want.readback_disabled),
                           32'(rsp_readback_disabled));
               check_field("write_position", 32'(want.write_position),
                           32'(rsp_write_position));
               check_field("end_position", 32'(want.end_position), 32'(rsp_end_position));
               check_field("read_data", 32'(want.read_data), 32'(rsp_read_data));
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 17);
      end
   end

   task automatic push_word(logic [afr_pkg::KIND_W-1:0] kind, logic [afr_pkg::BYTE_W-1:0] b,
                            logic [afr_pkg::POS_W-1:0] idx);
      line_word_type w;
      w.kind = kind;
      w.rx_byte = b;
      w.index = idx;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic push_byte(logic [afr_pkg::BYTE_W-1:0] b);
      push_word(afr_pkg::KIND_BYTE, b, rand_index());
   endtask

   task automatic write_reg(logic [afr_pkg::CSR_INDEX_W-1:0] idx,
                            logic [afr_pkg::BYTE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         afr_pkg::CSR_START_CODE:    cfg_start = value;
         afr_pkg::CSR_END_CODE:      cfg_end = value;
         afr_pkg::CSR_MODULE_ID:     cfg_module = value;
         afr_pkg::CSR_MODULE_SUB_ID: cfg_sub = value;
         default:                    cfg_broadcast = value;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_codes(logic [afr_pkg::BYTE_W-1:0] s, logic [afr_pkg::BYTE_W-1:0] e,
                              logic [afr_pkg::BYTE_W-1:0] m, logic [afr_pkg::BYTE_W-1:0] sub,
                              logic [afr_pkg::BYTE_W-1:0] bc);
      write_reg(afr_pkg::CSR_START_CODE, s);
      write_reg(afr_pkg::CSR_END_CODE, e);
      write_reg(afr_pkg::CSR_MODULE_ID, m);
      write_reg(afr_pkg::CSR_MODULE_SUB_ID, sub);
      write_reg(afr_pkg::CSR_BROADCAST_ID, bc);
   endtask

   // Every response comes back, so an empty expectation queue means idle.
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Frames, mostly well-formed, with random content, mixed with consumer
   // actions, noise bytes, broken headers and reserved kinds.
   task automatic gen_traffic(int unsigned count);
      int unsigned goal;
      int unsigned pick;
      int unsigned len;
      logic [afr_pkg::BYTE_W-1:0] b;
      goal = words_queued + count;
      while (words_queued < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            push_byte(cfg_start);
            if ($urandom_range(0, 9) == 0) push_byte(rand_byte());
            else push_byte($urandom_range(0, 1) ? cfg_module : cfg_broadcast);
            if ($urandom_range(0, 9) == 0) push_byte(rand_byte());
            else push_byte($urandom_range(0, 1) ? cfg_sub : cfg_broadcast);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
            repeat (len) begin
               do b = rand_byte();
               while (b == cfg_end && $urandom_range(0, 7) != 0);
               push_byte(b);
            end
            if ($urandom_range(0, 9) != 0) push_byte(cfg_end);
         end else if (pick < 65) begin
            push_word(afr_pkg::KIND_SET_START, rand_byte(), rand_index());
         end else if (pick < 75) begin
            push_word(afr_pkg::KIND_READ, rand_byte(), rand_index());
         end else if (pick < 80) begin
            push_word(afr_pkg::KIND_CLEAR_FLAGS, rand_byte(), rand_index());
         end else if (pick < 85) begin
            push_word(afr_pkg::KIND_DISABLE_RX, rand_byte(), rand_index());
         end else if (pick < 95) begin
            push_byte(rand_byte());
         end else begin
            push_word(afr_pkg::KIND_W'($urandom_range(32'(KIND_RESERVED_FIRST),
                                                      32'(KIND_RESERVED_LAST))),
                      rand_byte(), rand_index());
         end
      end
   endtask

   initial begin
      logic [afr_pkg::BYTE_W-1:0] b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      apply_codes(8'hA5, 8'h5A, 8'h12, 8'h34, 8'hFF);

      // One long frame fills every buffer slot, so later reads never hit an
      // entry that was never written. It also wraps into the overflow case.
      push_byte(cfg_start);
      push_byte(cfg_module);
      push_byte(cfg_sub);
      repeat (DEPTH) begin
         do b = rand_byte();
         while (b == cfg_end);
         push_byte(b);
      end
      push_byte(cfg_end);

      // Directed: index extremes, all kinds, broadcast match, header
      // mismatches, disabled reception and the unused kinds.
      push_word(afr_pkg::KIND_READ, 8'h00, '0);
      push_word(afr_pkg::KIND_READ, 8'hFF, '1);
      push_word(afr_pkg::KIND_SET_START, 8'hFF, '1);
      push_word(afr_pkg::KIND_SET_START, 8'h00, '0);
      push_word(afr_pkg::KIND_CLEAR_FLAGS, 8'h00, '0);
      push_byte(cfg_start);
      push_byte(cfg_broadcast);
      push_byte(cfg_broadcast);
      push_byte(8'h00);
      push_byte(cfg_end);
      push_byte(cfg_start);
      push_byte(8'h77);
      push_byte(cfg_start);
      push_byte(cfg_module);
      push_byte(8'h77);
      push_word(afr_pkg::KIND_DISABLE_RX, 8'h00, '0);
      push_byte(cfg_start);
      push_byte(cfg_end);
      push_word(KIND_RESERVED_FIRST, 8'hFF, '1);
      push_word(KIND_RESERVED_MID, 8'h00, '0);
      push_word(KIND_RESERVED_LAST, 8'hFF, '1);
      push_word(afr_pkg::KIND_READ, 8'h00, '1);
      gen_traffic(75);
      wait_idle();

      apply_codes(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80);
      gen_traffic(75);
      wait_idle();

      apply_codes(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
      gen_traffic(75);
      wait_idle();

      apply_codes(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
      gen_traffic(75);
      wait_idle();

      if (!failed && expected_status.size() == 0) begin
         $display("addressed_frame_receiver verification clean");
      end else begin
         $display("addressed_frame_receiver verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("addressed_frame_receiver verification failed");
      $finish;
   end

endmodule
